// ===== sv/stf_pkg.sv =====
// Shared types and constants for the sine tone with linear fade unit.
// No dependencies; imported by every module of the unit.
`default_nettype none

package stf_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_PHASE_STEP  = 2'd0;
    localparam logic [1:0] REG_NOTE_LENGTH = 2'd1;
    localparam logic [1:0] REG_FADE_STEP   = 2'd2;

    // Register reset values
    localparam logic [31:0] PHASE_STEP_RST  = 32'd42852281;
    localparam logic [15:0] NOTE_LENGTH_RST = 16'd44100;
    localparam logic [30:0] FADE_STEP_RST   = 31'd48684;

    // Amplitude at the start of a note, 32760.0 in Q16.16
    localparam logic [30:0] FULL_AMP_Q16 = 31'd2146959360;

    // pi in Q2.30
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    // Sample width, table entry magnitude width and amplitude width
    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = 15;
    localparam int AMP_W    = 31;

    // Sideband of one request as it travels down the pipe
    typedef struct packed {
        logic             idle;
        logic             last;
        logic             neg;
        logic [AMP_W-1:0] amp;
    } tone_req_t;

    // Unsigned 64-bit quotient by shift and subtract, used only at elaboration
    function automatic longint unsigned div_u64(input longint unsigned num,
                                                input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // sin(2*pi*r/2^bits) in Q15 for a quarter-wave offset r, Taylor series to x^15
    function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned r,
                                                      input int unsigned bits);
        longint unsigned x;
        longint unsigned term;
        longint          sum;
        longint unsigned q;
        longint unsigned k;
        x    = (64'd2 * PI_Q30 * longint'(r)) >> bits;
        term = x;
        sum  = longint'(x);
        for (k = 1; k <= 7; k++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = div_u64(term, (64'd2 * k) * (64'd2 * k + 64'd1));
            if (k[0]) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        q = (longint'(sum) + 64'd16384) >> 15;
        if (q > 64'd32767) begin
            q = 64'd32767;
        end
        return q[MAG_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== sv/sine_tone_with_linear_fade_unit.sv =====
// Top level of the sine tone with linear fade unit: one sample per request.
// Depends on stf_pkg, stf_phase_ctrl, stf_sine_rom and stf_scale_out.
//
//  channel   handshake               payload
//  s_        s_valid / s_ready       s_restart
//  m_        m_valid / m_ready       m_sample, m_last_of_note, m_idle
//  cfg_      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Three register stages: table address, table read, scaled result. One
// request is taken every cycle while the result side is not stalled.
// Each stage advances when the stage after it is empty or advancing, so a
// stalled result holds only the stages behind it that are full.
// Reset (aresetn, synchronous) clears the note state and restores the
// configuration defaults; no clearing pass. Configuration is always taken.
`default_nettype none

module sine_tone_with_linear_fade_unit #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [1:0]                     cfg_index,
    input  wire logic [31:0]                    cfg_data,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_restart,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic signed [stf_pkg::SAMPLE_W-1:0] m_sample,
    output logic                                m_last_of_note,
    output logic                                m_idle
);
    import stf_pkg::*;

    logic                       req_valid;
    logic                       req_ready;
    tone_req_t                  req;
    logic [SINE_TABLE_BITS-2:0] rom_addr;
    logic [MAG_W-1:0]           rom_data;

    assign cfg_ready = 1'b1;

    // Note state and table address
    stf_phase_ctrl #(
        .TABLE_BITS (SINE_TABLE_BITS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_restart (s_restart),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rom_addr  (rom_addr)
    );

    // Sine table lookup
    stf_sine_rom #(
        .TABLE_BITS (SINE_TABLE_BITS)
    ) u_rom (
        .aclk (aclk),
        .en   (req_ready),
        .addr (rom_addr),
        .data (rom_data)
    );

    // Amplitude scaling and result
    stf_scale_out u_out (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req            (req),
        .rom_data       (rom_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sample       (m_sample),
        .m_last_of_note (m_last_of_note),
        .m_idle         (m_idle)
    );

endmodule

`default_nettype wire

// ===== sv/stf_sine_rom.sv =====
// Quarter-wave sine table with registered read, built at elaboration.
// Depends on stf_pkg for quarter_sine and widths.
`default_nettype none

module stf_sine_rom #(
    parameter int TABLE_BITS = 10
) (
    input  wire logic                      aclk,
    input  wire logic                      en,
    input  wire logic [TABLE_BITS-2:0]     addr,
    output logic      [stf_pkg::MAG_W-1:0] data
);
    import stf_pkg::*;

    localparam int QDEPTH = (1 << (TABLE_BITS - 2)) + 1;

    typedef logic [MAG_W-1:0] qtab_t [QDEPTH];

    function automatic qtab_t build_qtab();
        qtab_t t;
        for (int i = 0; i < QDEPTH; i++) begin
            t[i] = quarter_sine(i, TABLE_BITS);
        end
        return t;
    endfunction

    localparam qtab_t QTAB = build_qtab();

    logic [MAG_W-1:0] data_reg;

    // Read one entry per advance of the pipe
    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= QTAB[addr];
        end
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// ===== sv/stf_phase_ctrl.sv =====
// Configuration registers, note state (phase, index, amplitude) and the
// first pipe stage that holds the table address. Depends on stf_pkg.
`default_nettype none

module stf_phase_ctrl #(
    parameter int TABLE_BITS = 10
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    // configuration
    input  wire logic                    cfg_valid,
    input  wire logic [1:0]              cfg_index,
    input  wire logic [31:0]             cfg_data,
    // request in
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic                    s_restart,
    // toward the table read
    output logic                         req_valid,
    input  wire logic                    req_ready,
    output stf_pkg::tone_req_t           req,
    output logic [TABLE_BITS-2:0]        rom_addr
);
    import stf_pkg::*;

    localparam logic [TABLE_BITS-2:0] QUARTER = (TABLE_BITS-1)'(1 << (TABLE_BITS - 2));

    logic [31:0]       phase_step_reg;
    logic [15:0]       note_length_reg;
    logic [AMP_W-1:0]  fade_step_reg;

    logic [31:0]       phase_reg,   phase_next;
    logic [15:0]       index_reg,   index_next;
    logic [AMP_W-1:0]  amp_reg,     amp_next;
    logic              playing_reg, playing_next;

    logic              valid_reg;
    tone_req_t         req_reg,     req_next;
    logic [TABLE_BITS-2:0] addr_reg, addr_next;

    logic              accept;
    logic              play;
    logic [31:0]       cur_phase;
    logic [15:0]       cur_index;
    logic [AMP_W-1:0]  cur_amp;
    logic              is_last;
    logic [TABLE_BITS-1:0] tab_idx;
    logic [TABLE_BITS-3:0] tab_off;

    assign s_ready = !valid_reg || req_ready;
    assign accept  = s_valid && s_ready;

    // Apply restart, then form the table address and the next state
    always_comb begin
        play      = s_restart || playing_reg;
        cur_phase = s_restart ? 32'd0 : phase_reg;
        cur_index = s_restart ? 16'd0 : index_reg;
        cur_amp   = s_restart ? FULL_AMP_Q16 : amp_reg;
        is_last   = cur_index == (note_length_reg - 16'd1);
        tab_idx   = cur_phase[31 -: TABLE_BITS];
        tab_off   = tab_idx[TABLE_BITS-3:0];

        phase_next   = phase_reg;
        index_next   = index_reg;
        amp_next     = amp_reg;
        playing_next = playing_reg;
        if (accept && play) begin
            phase_next   = cur_phase + phase_step_reg;
            index_next   = cur_index + 16'd1;
            amp_next     = (cur_amp > fade_step_reg) ? cur_amp - fade_step_reg : '0;
            playing_next = !is_last;
        end

        req_next.idle = !play;
        req_next.last = play && is_last;
        req_next.neg  = tab_idx[TABLE_BITS-1];
        req_next.amp  = play ? cur_amp : '0;
        // Odd quadrants read the table backwards from the quarter point
        if (tab_idx[TABLE_BITS-2]) begin
            addr_next = QUARTER - {1'b0, tab_off};
        end else begin
            addr_next = {1'b0, tab_off};
        end
    end

    // Hold configuration; ignore unknown indexes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_step_reg  <= PHASE_STEP_RST;
            note_length_reg <= NOTE_LENGTH_RST;
            fade_step_reg   <= FADE_STEP_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_PHASE_STEP:  phase_step_reg  <= cfg_data;
                REG_NOTE_LENGTH: note_length_reg <= cfg_data[15:0];
                REG_FADE_STEP:   fade_step_reg   <= cfg_data[AMP_W-1:0];
                default: ;
            endcase
        end
    end

    // Advance note state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= '0;
            index_reg   <= '0;
            amp_reg     <= '0;
            playing_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            index_reg   <= index_next;
            amp_reg     <= amp_next;
            playing_reg <= playing_next;
        end
    end

    // First pipe stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg  <= req_next;
            addr_reg <= addr_next;
        end
    end

    assign req_valid = valid_reg;
    assign req       = req_reg;
    assign rom_addr  = addr_reg;

endmodule

`default_nettype wire

// ===== sv/stf_scale_out.sv =====
// Table-read stage sideband, amplitude multiply and the result register.
// Depends on stf_pkg.
`default_nettype none

module stf_scale_out (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // from the address stage
    input  wire logic                          req_valid,
    output logic                               req_ready,
    input  wire stf_pkg::tone_req_t            req,
    // table entry, valid alongside the held sideband
    input  wire logic [stf_pkg::MAG_W-1:0]     rom_data,
    // result out
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [stf_pkg::SAMPLE_W-1:0] m_sample,
    output logic                               m_last_of_note,
    output logic                               m_idle
);
    import stf_pkg::*;

    logic       rd_valid_reg;
    tone_req_t  rd_req_reg;
    logic       out_valid_reg;
    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;
    logic       last_reg;
    logic       idle_reg;
    logic       out_ready;
    logic [AMP_W+MAG_W-1:0] prod;
    logic [SAMPLE_W-1:0]    mag;

    assign out_ready = !out_valid_reg || m_ready;
    assign req_ready = !rd_valid_reg || out_ready;

    // Scale the entry and restore its sign
    always_comb begin
        prod = (AMP_W+MAG_W)'(rd_req_reg.amp) * (AMP_W+MAG_W)'(rom_data);
        mag  = SAMPLE_W'(prod >> 31);
        if (rd_req_reg.idle) begin
            sample_next = '0;
        end else if (rd_req_reg.neg) begin
            sample_next = -$signed(mag);
        end else begin
            sample_next = $signed(mag);
        end
    end

    // Table read stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else if (req_ready) begin
            rd_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (req_ready) begin
            rd_req_reg <= req;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= rd_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && rd_valid_reg) begin
            sample_reg <= sample_next;
            last_reg   <= rd_req_reg.last;
            idle_reg   <= rd_req_reg.idle;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_sample       = sample_reg;
    assign m_last_of_note = last_reg;
    assign m_idle         = idle_reg;

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking bench for sine_tone_with_linear_fade_unit.
// Depends on stf_pkg and the unit's RTL. A scoreboard class models the
// note state and compares every output sample in request order.
`timescale 1ns / 100ps

module tb_top;
    import stf_pkg::*;

    localparam int TABLE_BITS = 10;
    localparam int TABLE_SIZE = 1 << TABLE_BITS;
    localparam int QUARTER    = TABLE_SIZE / 4;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_MAX = 10;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_TICKS = 108;
    localparam int WRAP_TICKS = 40;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
        logic                       idle;
    } tone_out_t;

    // Note model: phase accumulator, fade and sine lookup per tick
    class tone_scoreboard;
        int          sine_rom[TABLE_SIZE];
        logic [31:0] step_reg;
        logic [15:0] length_reg;
        logic [30:0] fade_reg;
        logic [31:0] phase_acc;
        logic [15:0] sample_cnt;
        logic [31:0] amp_q16;
        bit          playing;
        tone_out_t   expected_samples[$];
        int          mismatches;

        function new();
            int i;
            int v;
            for (i = 0; i < TABLE_SIZE; i++) begin
                v = ((i / QUARTER) % 2) ? quarter_wave(QUARTER - i % QUARTER)
                                        : quarter_wave(i % QUARTER);
                sine_rom[i] = (i / QUARTER >= 2) ? -v : v;
            end
            step_reg   = PHASE_STEP_RST;
            length_reg = NOTE_LENGTH_RST;
            fade_reg   = FADE_STEP_RST;
            phase_acc  = '0;
            sample_cnt = '0;
            amp_q16    = '0;
            playing    = 1'b0;
            mismatches = 0;
        endfunction

        // Q15 sine over a quarter wave from a truncated Taylor series
        function int quarter_wave(int unsigned r);
            longint unsigned ang;
            longint unsigned pw;
            longint unsigned rnd;
            longint          acc;
            int unsigned     n;
            ang = (64'd2 * PI_Q30 * 64'(r)) >> TABLE_BITS;
            pw  = ang;
            acc = longint'(ang);
            for (n = 1; n <= 7; n++) begin
                pw = (pw * ang) >> 30;
                pw = (pw * ang) >> 30;
                pw = pw / (64'(2 * n) * 64'(2 * n + 1));
                acc = n[0] ? acc - longint'(pw) : acc + longint'(pw);
            end
            if (acc < 0) begin
                acc = 0;
            end
            rnd = ($unsigned(acc) + 64'd16384) >> 15;
            return (rnd > 64'd32767) ? 32767 : int'(rnd);
        endfunction

        function void note_write(logic [1:0] idx, logic [31:0] data);
            case (idx)
                REG_PHASE_STEP:  step_reg   = data;
                REG_NOTE_LENGTH: length_reg = data[15:0];
                REG_FADE_STEP:   fade_reg   = data[30:0];
                default: ;
            endcase
        endfunction

        // Advance the note by one request and queue the sample it yields
        function void note_tick(logic restart);
            tone_out_t       res;
            int              ent;
            int              mag;
            longint unsigned prod;
            logic [15:0]     scaled;
            logic [15:0]     final_cnt;
            if (restart) begin
                phase_acc  = '0;
                sample_cnt = '0;
                amp_q16    = {1'b0, FULL_AMP_Q16};
                playing    = 1'b1;
            end
            if (!playing) begin
                res.sample = '0;
                res.last   = 1'b0;
                res.idle   = 1'b1;
            end else begin
                ent        = sine_rom[phase_acc[31 -: TABLE_BITS]];
                mag        = (ent < 0) ? -ent : ent;
                prod       = 64'(amp_q16) * 64'(mag);
                scaled     = 16'(prod >> 31);
                final_cnt  = length_reg - 16'd1;
                res.sample = (ent < 0) ? -scaled : scaled;
                res.last   = (sample_cnt == final_cnt);
                res.idle   = 1'b0;
                phase_acc  = phase_acc + step_reg;
                sample_cnt = sample_cnt + 16'd1;
                amp_q16    = (amp_q16 > {1'b0, fade_reg}) ? amp_q16 - {1'b0, fade_reg} : '0;
                if (res.last) begin
                    playing = 1'b0;
                end
            end
            expected_samples.push_back(res);
        endfunction

        function void check_result(logic signed [SAMPLE_W-1:0] sample, logic last,
                                   logic idle);
            tone_out_t exp_res;
            if (expected_samples.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("result error: unexpected sample %0d last %0b idle %0b",
                             sample, last, idle);
                end
                return;
            end
            exp_res = expected_samples.pop_front();
            if (sample !== exp_res.sample || last !== exp_res.last ||
                idle !== exp_res.idle) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("result error: expected sample %0d last %0b idle %0b, got %0d %0b %0b",
                             exp_res.sample, exp_res.last, exp_res.idle, sample, last, idle);
                end
            end
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction
    endclass

    logic                       aclk = 1'b0;
    logic                       aresetn;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [1:0]                 cfg_index;
    logic [31:0]                cfg_data;
    logic                       s_valid;
    logic                       s_ready;
    logic                       s_restart;
    logic                       m_valid;
    logic                       m_ready;
    logic signed [SAMPLE_W-1:0] m_sample;
    logic                       m_last_of_note;
    logic                       m_idle;

    tone_scoreboard sb;
    int s_gap_max;
    int m_gap_max;
    int quiet_cycles;

    sine_tone_with_linear_fade_unit #(
        .SINE_TABLE_BITS(TABLE_BITS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_restart     (s_restart),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sample      (m_sample),
        .m_last_of_note(m_last_of_note),
        .m_idle        (m_idle)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Observe every handshake at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                sb.note_write(cfg_index, cfg_data);
            end
            if (s_valid && s_ready) begin
                sb.note_tick(s_restart);
            end
            if (m_valid && m_ready) begin
                sb.check_result(m_sample, m_last_of_note, m_idle);
            end
        end
    end

    // Abort when no request moves on any channel for too long
    always @(posedge aclk) begin
        if (!aresetn || (cfg_valid && cfg_ready) || (s_valid && s_ready) ||
            (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side: stall a random number of cycles before each sample
    initial begin : sink
        int stall;
        m_ready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            stall = $urandom_range(0, m_gap_max);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    // Send one tick request after a random gap; call and return at a falling edge
    task automatic tick(input logic restart);
        int gap;
        gap = $urandom_range(0, s_gap_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_restart <= restart;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Drop valid and hold until every queued sample has come back
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
    endtask

    task automatic put_reg(input logic [1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Write all registers with junk in the unused upper bits
    task automatic program_regs(input logic [31:0] ps, input logic [15:0] nl,
                                input logic [30:0] fs);
        logic [31:0] junk;
        junk = $urandom;
        put_reg(REG_PHASE_STEP, ps);
        put_reg(REG_NOTE_LENGTH, {junk[31:16], nl});
        put_reg(REG_FADE_STEP, {junk[0], fs});
        put_reg(REG_UNUSED, $urandom);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int          ph;
        int          n;
        logic [31:0] ps;
        logic [15:0] nl;
        logic [30:0] fs;
        logic        restart;

        sb        = new();
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_valid   = 1'b0;
        s_restart = 1'b0;
        s_gap_max = 0;
        m_gap_max = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Ticks before any note, then a note on the reset settings
        tick(1'b0);
        tick(1'b0);
        tick(1'b1);
        tick(1'b0);
        tick(1'b0);
        drain();

        // Quarter-wave step, no fade: carry on the old note, then a short one
        program_regs(32'h4000_0000, 16'd3, 31'd0);
        tick(1'b0);
        tick(1'b1);
        tick(1'b0);
        tick(1'b0);
        tick(1'b0);
        drain();

        // Largest step and fade: amplitude clamps to zero, one-sample notes
        program_regs(32'hFFFF_FFFF, 16'd1, 31'h7FFF_FFFF);
        tick(1'b1);
        tick(1'b1);
        tick(1'b0);
        drain();

        // Restart while a note is playing
        program_regs(32'h0800_0000, 16'd5, 31'(32'd2146959360 / 32'd5));
        tick(1'b1);
        tick(1'b0);
        tick(1'b1);
        repeat (5) tick(1'b0);
        tick(1'b0);
        drain();

        // Random settings with random gaps on both sides
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            case ($urandom_range(0, 5))
                0:       ps = '0;
                1:       ps = 32'hFFFF_FFFF;
                default: ps = $urandom;
            endcase
            case ($urandom_range(0, 7))
                0:       nl = 16'd1;
                1:       nl = 16'hFFFF;
                default: nl = 16'($urandom_range(2, 40));
            endcase
            case ($urandom_range(0, 5))
                0:       fs = '0;
                1:       fs = 31'h7FFF_FFFF;
                2:       fs = 31'($urandom);
                default: fs = 31'(32'd2146959360 / 32'(nl));
            endcase
            case ($urandom_range(0, 2))
                0:       s_gap_max = 0;
                1:       s_gap_max = 3;
                default: s_gap_max = 18;
            endcase
            case ($urandom_range(0, 2))
                0:       m_gap_max = 0;
                1:       m_gap_max = 3;
                default: m_gap_max = 18;
            endcase
            program_regs(ps, nl, fs);
            for (n = 0; n < PHASE_TICKS; n++) begin
                // Mostly whole notes, with idle ticks and the odd early restart
                if (!sb.playing) begin
                    restart = ($urandom_range(0, 3) == 0);
                end else begin
                    restart = ($urandom_range(0, 49) == 0);
                end
                tick(restart);
            end
            drain();
        end

        // Zero note length wraps to a 65536-sample note: no early last flag
        s_gap_max = 0;
        m_gap_max = 0;
        program_regs($urandom, 16'd0, 31'd30);
        tick(1'b1);
        repeat (WRAP_TICKS) tick(1'b0);
        drain();

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/stf_pkg.sv
sv/stf_sine_rom.sv
sv/stf_phase_ctrl.sv
sv/stf_scale_out.sv
sv/sine_tone_with_linear_fade_unit.sv
dv/tb_top.sv
